// ----- design/tpp_pkg.sv -----
`default_nettype none
package tpp_pkg;

    // tick rate width (rates up to 1e6 per second)
    localparam int TW     = 20;
    // one tick word + 1
    localparam int TKW    = 21;
    localparam int CW     = 24;
    // divider widths: numerator is 2n, denominator up to vv*A*T^2
    localparam int NUM_W  = 137;
    localparam int DEN_W  = 112;
    localparam int QB     = 26;
    localparam int REM_W  = 139;
    localparam int POS_W  = 25;
    localparam logic [POS_W-1:0] POS_ONE = 25'h100_0000;

    // register indexes on the config port
    localparam logic CFG_PEAK_SPEED  = 1'b0;
    localparam logic CFG_ACCEL_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PH_ACC,
        PH_CRU,
        PH_DEC,
        PH_FIN
    } tpp_phase_t;

    // sideband that rides along with each word through the divider
    typedef struct packed {
        tpp_phase_t phase;
        logic       finished;
    } tpp_tag_t;

endpackage
`default_nettype wire

// ----- design/tpp_front.sv -----
`default_nettype none
module tpp_front #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [19:0]               tick,
    input  wire logic [tpp_pkg::CW-1:0]    peak,
    input  wire logic [tpp_pkg::CW-1:0]    accel,
    output logic                           out_valid,
    output logic [tpp_pkg::NUM_W-1:0]      num,
    output logic [tpp_pkg::DEN_W-1:0]      den,
    output tpp_pkg::tpp_tag_t              tag
);
    import tpp_pkg::*;

    localparam logic [TW-1:0]   TPS    = TW'(TICKS_PER_SECOND);
    localparam logic [2*TW-1:0] TPS_SQ = (2*TW)'(TICKS_PER_SECOND) * (2*TW)'(TICKS_PER_SECOND);

    logic [5:0] vld_reg;

    // stage 1: tick + 1, zero registers read as one
    logic [TKW-1:0] t1_reg;
    logic [CW-1:0]  v1_reg, a1_reg;

    // stage 2: first products
    logic [44:0] tv2_reg, ta2_reg;
    logic [47:0] vv2_reg;
    logic [41:0] tt2_reg;
    logic [43:0] tvc2_reg;
    logic [CW-1:0] a2_reg;

    // stage 3: second products and compares
    logic [68:0] tva3_reg, endl3_reg;
    logic [65:0] tta3_reg;
    logic [67:0] vvt3_reg;
    logic [71:0] vva3_reg;
    logic [43:0] ta3_reg;
    logic [44:0] tv3_reg;
    logic        tri3_reg, ph0_3_reg, lt16_3_reg, lt17_3_reg;

    // stage 4: phase decision, operand selection
    logic [63:0]        x4_reg, x4_next;
    logic [NUM_W-2:0]   n4_reg, n4_next;
    logic [DEN_W-1:0]   d4_reg, d4_next;
    logic               sq4_reg, sq4_next, sh4_reg, sh4_next;
    tpp_tag_t           tag4_reg, tag4_next;

    // stage 5: partial products of the square
    logic [63:0]        hh5_reg, hl5_reg, ll5_reg;
    logic [NUM_W-2:0]   n5_reg;
    logic [DEN_W-1:0]   d5_reg;
    logic               sq5_reg, sh5_reg;
    tpp_tag_t           tag5_reg;

    // stage 6: numerator assembly
    logic [NUM_W-1:0]   num6_reg, num6_next;
    logic [DEN_W-1:0]   d6_reg;
    tpp_tag_t           tag6_reg;

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // stages 1 to 3
    always_ff @(posedge clk)
    begin
        t1_reg     <= TKW'(tick) + TKW'(1);
        v1_reg     <= (peak == '0)  ? CW'(1) : peak;
        a1_reg     <= (accel == '0) ? CW'(1) : accel;

        tv2_reg    <= 45'(t1_reg) * 45'(v1_reg);
        ta2_reg    <= 45'(t1_reg) * 45'(a1_reg);
        vv2_reg    <= 48'(v1_reg) * 48'(v1_reg);
        tt2_reg    <= 42'(t1_reg) * 42'(t1_reg);
        tvc2_reg   <= 44'(TPS) * 44'(v1_reg);
        a2_reg     <= a1_reg;

        tva3_reg   <= 69'(tv2_reg) * 69'(a2_reg);
        endl3_reg  <= 69'(TPS) * (69'({a2_reg, 16'b0}) + 69'(vv2_reg));
        tta3_reg   <= 66'(tt2_reg) * 66'(a2_reg);
        vvt3_reg   <= 68'(vv2_reg) * 68'(TPS);
        vva3_reg   <= 72'(vv2_reg) * 72'(a2_reg);
        ta3_reg    <= 44'(TPS) * 44'(a2_reg);
        tv3_reg    <= tv2_reg;
        tri3_reg   <= vv2_reg > 48'({a2_reg, 16'b0});
        ph0_3_reg  <= 45'(ta2_reg) < 45'(tvc2_reg);
        lt16_3_reg <= 64'(tv2_reg) < (64'(TPS) << 16);
        lt17_3_reg <= 64'(tv2_reg) < (64'(TPS) << 17);
    end

    // stage 4: pick phase, square operand or linear numerator, denominator
    always_comb
    begin
        x4_next   = '0;
        n4_next   = '0;
        d4_next   = DEN_W'(TPS_SQ) << 9;
        sq4_next  = 1'b1;
        sh4_next  = 1'b0;
        tag4_next = '{phase: PH_FIN, finished: 1'b1};
        if (tri3_reg)
        begin
            // triangle: tv/T^2 parabola up, mirrored one down
            if (lt17_3_reg)
            begin
                tag4_next.finished = 1'b0;
                if (lt16_3_reg)
                begin
                    tag4_next.phase = PH_ACC;
                    x4_next = 64'(tv3_reg);
                end
                else
                begin
                    tag4_next.phase = PH_DEC;
                    x4_next = 64'((64'(TPS) << 17) - 64'(tv3_reg));
                end
            end
        end
        else if (tva3_reg < endl3_reg)
        begin
            tag4_next.finished = 1'b0;
            if (ph0_3_reg)
            begin
                tag4_next.phase = PH_ACC;
                sq4_next = 1'b0;
                n4_next  = (NUM_W-1)'(tta3_reg) << 7;
                d4_next  = DEN_W'(TPS_SQ);
            end
            else if (lt16_3_reg)
            begin
                tag4_next.phase = PH_CRU;
                sq4_next = 1'b0;
                n4_next  = ((NUM_W-1)'(tva3_reg) << 1) - (NUM_W-1)'(vvt3_reg);
                n4_next  = n4_next << 7;
                d4_next  = DEN_W'(ta3_reg);
            end
            else
            begin
                tag4_next.phase = PH_DEC;
                sh4_next = 1'b1;
                x4_next  = 64'(endl3_reg - tva3_reg);
                d4_next  = DEN_W'(vva3_reg) * DEN_W'(TPS_SQ);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x4_reg   <= x4_next;
        n4_reg   <= n4_next;
        d4_reg   <= d4_next;
        sq4_reg  <= sq4_next;
        sh4_reg  <= sh4_next;
        tag4_reg <= tag4_next;

        hh5_reg  <= 64'(x4_reg[63:32]) * 64'(x4_reg[63:32]);
        hl5_reg  <= 64'(x4_reg[63:32]) * 64'(x4_reg[31:0]);
        ll5_reg  <= 64'(x4_reg[31:0]) * 64'(x4_reg[31:0]);
        n5_reg   <= n4_reg;
        d5_reg   <= d4_reg;
        sq5_reg  <= sq4_reg;
        sh5_reg  <= sh4_reg;
        tag5_reg <= tag4_reg;

        num6_reg <= num6_next;
        d6_reg   <= d5_reg;
        tag6_reg <= tag5_reg;
    end

    // stage 6: add partial products, scale, double for rounding
    always_comb
    begin
        logic [127:0]     sq_val;
        logic [NUM_W-2:0] n_sel;
        sq_val = {hh5_reg, 64'b0} + (128'(hl5_reg) << 33) + 128'(ll5_reg);
        if (sq5_reg)
        begin
            n_sel = sh5_reg ? ((NUM_W-1)'(sq_val) << 7) : (NUM_W-1)'(sq_val);
        end
        else
        begin
            n_sel = n5_reg;
        end
        num6_next = {n_sel, 1'b0};
    end

    assign out_valid = vld_reg[5];
    assign num       = num6_reg;
    assign den       = d6_reg;
    assign tag       = tag6_reg;

endmodule
`default_nettype wire

// ----- design/tpp_div.sv -----
`default_nettype none
module tpp_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [tpp_pkg::NUM_W-1:0] num,
    input  wire logic [tpp_pkg::DEN_W-1:0] den,
    input  wire tpp_pkg::tpp_tag_t         tag_in,
    output logic                           out_valid,
    output logic [tpp_pkg::QB-1:0]         quot,
    output logic                           ovf,
    output tpp_pkg::tpp_tag_t              tag_out
);
    import tpp_pkg::*;

    // restoring divider, one quotient bit per stage, MSB first
    logic [QB:0]        vld_reg;
    logic [REM_W-1:0]   rem_reg [QB+1];
    logic [DEN_W-1:0]   den_reg [QB+1];
    logic [QB-1:0]      q_reg   [QB+1];
    logic               ovf_reg [QB+1];
    tpp_tag_t           tag_reg [QB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QB-1:0], in_valid};
        end
    end

    // entry: quotient must fit in QB bits, else ovf is flagged
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= REM_W'(num);
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        ovf_reg[0] <= REM_W'(num) >= (REM_W'(den) << QB);
        tag_reg[0] <= tag_in;
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_step
        logic [REM_W-1:0] dsh;
        logic             take;
        assign dsh  = REM_W'(den_reg[j]) << (QB - 1 - j);
        assign take = rem_reg[j] >= dsh;

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= take ? rem_reg[j] - dsh : rem_reg[j];
            q_reg[j+1]   <= q_reg[j] | (take ? (QB'(1) << (QB - 1 - j)) : '0);
            den_reg[j+1] <= den_reg[j];
            ovf_reg[j+1] <= ovf_reg[j];
            tag_reg[j+1] <= tag_reg[j];
        end
    end

    assign out_valid = vld_reg[QB];
    assign quot      = q_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign tag_out   = tag_reg[QB];

endmodule
`default_nettype wire

// ----- design/trapezoid_profile_position.sv -----
`default_nettype none
// Normalized trapezoidal profile: one tick_index word is taken on every
// cycle (busy stays low), and its position, phase and finished flags appear
// on done in order. The receiver cannot stall. The path runs through 6
// front-end stages, one range check plus 26 stages of a one-bit-per-stage
// divider, and the output register. Positions are rounded to nearest,
// halves up; past the end of the move position holds at 1.0.
// Register 0 is peak_speed, register 1 accel_limit (Q8.16); write them only
// while no word is in flight. cfg_ready is always high.
module trapezoid_profile_position #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [19:0]              tick_index,
    output logic                          done,
    output logic [tpp_pkg::POS_W-1:0]     position,
    output logic [1:0]                    phase,
    output logic                          finished,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_addr,
    input  wire logic [tpp_pkg::CW-1:0]   cfg_data
);
    import tpp_pkg::*;

    localparam int LAT = 6 + QB + 2;

    logic [CW-1:0]  peak_reg, accel_reg;
    logic           f_valid, d_valid, d_ovf;
    logic [NUM_W-1:0] f_num;
    logic [DEN_W-1:0] f_den;
    tpp_tag_t       f_tag, d_tag;
    logic [QB-1:0]  d_q;

    logic             done_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    tpp_phase_t       ph_reg;
    logic             fin_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= CW'(65536);
            accel_reg <= CW'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_PEAK_SPEED:  peak_reg  <= cfg_data;
                CFG_ACCEL_LIMIT: accel_reg <= cfg_data;
                default:         peak_reg  <= peak_reg;
            endcase
        end
    end

    tpp_front #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .tick      (tick_index),
        .peak      (peak_reg),
        .accel     (accel_reg),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .tag       (f_tag)
    );

    tpp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .tag_in    (f_tag),
        .out_valid (d_valid),
        .quot      (d_q),
        .ovf       (d_ovf),
        .tag_out   (d_tag)
    );

    // round half up, clamp, mirror the deficit while decelerating
    always_comb
    begin
        logic [QB-1:0] qr;
        logic          big, full;
        qr   = QB'((QB+1)'(d_q) + (QB+1)'(1) >> 1);
        big  = d_ovf || (qr > QB'(POS_ONE));
        full = d_ovf || (qr >= QB'(POS_ONE));
        unique case (d_tag.phase)
            PH_ACC, PH_CRU: pos_next = big ? POS_ONE : POS_W'(qr);
            PH_DEC:         pos_next = full ? '0 : POS_ONE - POS_W'(qr);
            default:        pos_next = POS_ONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        ph_reg  <= d_tag.phase;
        fin_reg <= d_tag.finished;
    end

    assign done     = done_reg;
    assign position = pos_reg;
    assign phase    = ph_reg;
    assign finished = fin_reg;

`ifndef SYNTH
    // every accepted word comes out on done after the front end, divider and output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("result missing at fixed latency");

    // finished flag and phase code agree
    a_fin_phase: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (finished == (phase == PH_FIN)))
        else $error("finished flag disagrees with phase");

    // past the end the position sits at 1.0
    a_fin_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && finished |-> position == POS_ONE)
        else $error("finished position is not 1.0");

    // position never exceeds 1.0
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> position <= POS_ONE)
        else $error("position above 1.0");
`endif

endmodule
`default_nettype wire
